### hw/rtl/coalescing_priority_send_queue_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the coalescing priority send queue
// Shared same-cycle-implication and next-cycle property wrappers.
// ---------------------------------------------------------------------------
`ifndef COALESCING_PRIORITY_SEND_QUEUE_DEFINES_SVH
`define COALESCING_PRIORITY_SEND_QUEUE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CPSQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CPSQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cpsq_pkg.sv
// ---------------------------------------------------------------------------
// Coalescing priority send queue package
// Shared types, codes and constants of the send queue.
// ---------------------------------------------------------------------------
package cpsq_pkg;

    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_SEND    = 2'd1;
    localparam logic [1:0] CMD_CLOSE   = 2'd2;

    localparam logic [2:0] CLS_RELIABLE  = 3'd0;
    localparam logic [2:0] CLS_HANDSHAKE = 3'd1;
    localparam logic [2:0] CLS_CURSOR    = 3'd2;
    localparam logic [2:0] CLS_HASH      = 3'd4;

    localparam logic [1:0] LIFE_NONE  = 2'd0;
    localparam logic [1:0] LIFE_BEGIN = 2'd1;
    localparam logic [1:0] LIFE_SUPER = 2'd2;

    localparam logic [1:0] SEND_OK      = 2'd0;
    localparam logic [1:0] SEND_BLOCK   = 2'd1;
    localparam logic [1:0] SEND_CLOSED  = 2'd2;
    localparam logic [1:0] SEND_FAILED  = 2'd3;

    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_NOT_OPEN   = 3'd1;
    localparam logic [2:0] STAT_ENCODE     = 3'd2;
    localparam logic [2:0] STAT_BUDGET     = 3'd3;
    localparam logic [2:0] STAT_SEND_FAIL  = 3'd4;
    localparam logic [2:0] STAT_QUEUE_FULL = 3'd5;

    localparam logic [1:0] LINK_CONNECTED = 2'd0;
    localparam logic [1:0] LINK_CLOSED    = 2'd1;
    localparam logic [1:0] LINK_FAILED    = 2'd2;

    localparam logic [23:0] BUDGET_RESET = 24'hFFFF00;

    typedef struct packed {
        logic [2:0]  cls;
        logic [63:0] key;
        logic [15:0] len;
        logic [15:0] tag;
    } entry_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  packet_class;
        logic [1:0]  lifecycle_kind;
        logic [63:0] coalesce_key;
        logic [15:0] packet_length;
        logic [15:0] packet_tag;
        logic [1:0]  send_status;
        logic [15:0] sent_bytes;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  channel_state;
        logic [23:0] queued_bytes;
        logic [6:0]  queue_count;
        logic        head_valid;
        logic [15:0] head_tag;
        logic [15:0] head_remaining;
        logic        packet_done;
    } result_t;

    typedef enum logic [1:0] {
        DISC_KEY,
        DISC_PRES,
        DISC_ALL
    } disc_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DISC_RD,
        ST_DISC_USE,
        ST_CHECK,
        ST_POS_RD,
        ST_POS_USE,
        ST_SHIFT_RD,
        ST_SHIFT_USE,
        ST_INSERT,
        ST_POP_RD,
        ST_POP_USE,
        ST_HEAD_RD,
        ST_HEAD_USE,
        ST_DONE
    } state_t;

endpackage

### hw/rtl/cpsq_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module cpsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/cpsq_ctrl.sv
// ---------------------------------------------------------------------------
// Send queue sequencer
// Walks the descriptor RAM one entry at a time for discard, insert and pop.
// ---------------------------------------------------------------------------
module cpsq_ctrl #(
    parameter int QUEUE_DEPTH      = 64,
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cpsq_pkg::item_t  in_item,
    input  logic [23:0]      budget,
    output logic             res_valid,
    input  logic             res_ready,
    output cpsq_pkg::result_t res
);
    import cpsq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    state_t          state_reg, state_next;
    item_t           item_reg;
    disc_mode_t      mode_reg, mode_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   r_reg, r_next;
    logic [CW-1:0]   w_reg, w_next;
    logic [15:0]     off_reg, off_next;
    logic [23:0]     total_reg, total_next;
    logic [1:0]      link_reg, link_next;
    logic [2:0]      status_reg, status_next;
    logic            done_reg, done_next;
    logic [15:0]     htag_reg, htag_next;
    logic [15:0]     hlen_reg, hlen_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    entry_t          ram_wdata, ram_rdata;

    logic            is_pres, is_rel, drop, protect;
    logic [15:0]     rem, sent_n;
    logic [23:0]     room;
    entry_t          new_entry;

    cpsq_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mode_reg   <= DISC_KEY;
            count_reg  <= '0;
            r_reg      <= '0;
            w_reg      <= '0;
            off_reg    <= '0;
            total_reg  <= '0;
            link_reg   <= LINK_CONNECTED;
            status_reg <= STAT_OK;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            r_reg      <= r_next;
            w_reg      <= w_next;
            off_reg    <= off_next;
            total_reg  <= total_next;
            link_reg   <= link_next;
            status_reg <= status_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
        htag_reg <= htag_next;
        hlen_reg <= hlen_next;
    end

    assign new_entry = '{cls: item_reg.packet_class, key: item_reg.coalesce_key,
                         len: item_reg.packet_length, tag: item_reg.packet_tag};

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        count_next  = count_reg;
        r_next      = r_reg;
        w_next      = w_reg;
        off_next    = off_reg;
        total_next  = total_reg;
        link_next   = link_reg;
        status_next = status_reg;
        done_next   = done_reg;
        htag_next   = htag_reg;
        hlen_next   = hlen_reg;
        ram_we      = 1'b0;
        ram_waddr   = w_reg[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = r_reg[AW-1:0];
        in_ready    = 1'b0;
        res_valid   = 1'b0;

        is_pres = (ram_rdata.cls >= CLS_CURSOR) && (ram_rdata.cls <= CLS_HASH);
        is_rel  = (ram_rdata.cls == CLS_RELIABLE) || (ram_rdata.cls > CLS_HASH);
        protect = (r_reg == '0) && (off_reg != '0);
        unique case (mode_reg)
            DISC_KEY:  drop = (ram_rdata.cls == item_reg.packet_class) &&
                              (ram_rdata.key == item_reg.coalesce_key);
            DISC_PRES: drop = is_pres;
            DISC_ALL:  drop = is_pres || is_rel;
            default:   drop = 1'b0;
        endcase

        rem    = hlen_reg - off_reg;
        sent_n = (item_reg.sent_bytes > rem) ? rem : item_reg.sent_bytes;
        room   = (total_reg > budget) ? 24'd0 : budget - total_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    status_next = STAT_OK;
                    done_next   = 1'b0;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_HEAD_RD;
                priority case (item_reg.command)
                    CMD_ENQUEUE:
                    begin
                        if (link_reg != LINK_CONNECTED)
                        begin
                            status_next = STAT_NOT_OPEN;
                        end
                        else if (item_reg.packet_length == 16'd0 ||
                                 {1'b0, item_reg.packet_length} > 17'(MAX_PACKET_BYTES))
                        begin
                            status_next = STAT_ENCODE;
                            count_next  = '0;
                            off_next    = '0;
                            total_next  = '0;
                            link_next   = LINK_FAILED;
                        end
                        else
                        begin
                            r_next     = '0;
                            w_next     = '0;
                            state_next = ST_DISC_RD;
                            if (item_reg.lifecycle_kind == LIFE_SUPER)
                            begin
                                mode_next = DISC_ALL;
                            end
                            else if (item_reg.lifecycle_kind == LIFE_BEGIN)
                            begin
                                mode_next = DISC_PRES;
                            end
                            else if (item_reg.packet_class >= CLS_CURSOR &&
                                     item_reg.packet_class <= CLS_HASH)
                            begin
                                mode_next = DISC_KEY;
                            end
                            else
                            begin
                                state_next = ST_CHECK;
                            end
                        end
                    end
                    CMD_SEND:
                    begin
                        if (link_reg != LINK_CONNECTED)
                        begin
                            status_next = STAT_NOT_OPEN;
                        end
                        else if (count_reg == '0 || item_reg.send_status == SEND_BLOCK)
                        begin
                            status_next = STAT_OK;
                        end
                        else if (item_reg.send_status == SEND_CLOSED)
                        begin
                            count_next = '0;
                            off_next   = '0;
                            total_next = '0;
                            link_next  = LINK_CLOSED;
                        end
                        else if (item_reg.send_status == SEND_FAILED ||
                                 item_reg.sent_bytes == 16'd0)
                        begin
                            status_next = STAT_SEND_FAIL;
                            count_next  = '0;
                            off_next    = '0;
                            total_next  = '0;
                            link_next   = LINK_FAILED;
                        end
                        else
                        begin
                            total_next = total_reg - {8'd0, sent_n};
                            off_next   = off_reg + sent_n;
                            if (sent_n == rem)
                            begin
                                off_next   = '0;
                                done_next  = 1'b1;
                                count_next = count_reg - 1'b1;
                                w_next     = CW'(1);
                                state_next = ST_POP_RD;
                            end
                        end
                    end
                    CMD_CLOSE:
                    begin
                        count_next = '0;
                        off_next   = '0;
                        total_next = '0;
                        if (link_reg != LINK_FAILED)
                        begin
                            link_next = LINK_CLOSED;
                        end
                    end
                    default:
                    begin
                        status_next = STAT_OK;
                    end
                endcase
            end
            ST_DISC_RD:
            begin
                if (r_reg == count_reg)
                begin
                    count_next = w_reg;
                    state_next = ST_CHECK;
                end
                else
                begin
                    state_next = ST_DISC_USE;
                end
            end
            ST_DISC_USE:
            begin
                if (drop && !protect)
                begin
                    total_next = total_reg - {8'd0, ram_rdata.len};
                end
                else
                begin
                    ram_we = 1'b1;
                    w_next = w_reg + 1'b1;
                end
                r_next     = r_reg + 1'b1;
                state_next = ST_DISC_RD;
            end
            ST_CHECK:
            begin
                if ({8'd0, item_reg.packet_length} > room)
                begin
                    status_next = STAT_BUDGET;
                    count_next  = '0;
                    off_next    = '0;
                    total_next  = '0;
                    link_next   = LINK_FAILED;
                    state_next  = ST_HEAD_RD;
                end
                else if (count_reg >= CW'(QUEUE_DEPTH))
                begin
                    status_next = STAT_QUEUE_FULL;
                    count_next  = '0;
                    off_next    = '0;
                    total_next  = '0;
                    link_next   = LINK_FAILED;
                    state_next  = ST_HEAD_RD;
                end
                else if (item_reg.lifecycle_kind == LIFE_BEGIN ||
                         item_reg.lifecycle_kind == LIFE_SUPER)
                begin
                    r_next     = (count_reg != '0 && off_reg != '0) ? CW'(1) : '0;
                    state_next = ST_POS_RD;
                end
                else
                begin
                    r_next     = count_reg;
                    state_next = ST_INSERT;
                end
            end
            ST_POS_RD:
            begin
                if (r_reg >= count_reg)
                begin
                    w_next     = count_reg;
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    state_next = ST_POS_USE;
                end
            end
            ST_POS_USE:
            begin
                if (ram_rdata.cls == CLS_HANDSHAKE)
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_POS_RD;
                end
                else
                begin
                    w_next     = count_reg;
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_SHIFT_RD:
            begin
                ram_raddr = AW'(w_reg - 1'b1);
                state_next = (w_reg == r_reg) ? ST_INSERT : ST_SHIFT_USE;
            end
            ST_SHIFT_USE:
            begin
                ram_we     = 1'b1;
                w_next     = w_reg - 1'b1;
                state_next = ST_SHIFT_RD;
            end
            ST_INSERT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = r_reg[AW-1:0];
                ram_wdata  = new_entry;
                count_next = count_reg + 1'b1;
                total_next = total_reg + {8'd0, item_reg.packet_length};
                state_next = ST_HEAD_RD;
            end
            ST_POP_RD:
            begin
                ram_raddr  = w_reg[AW-1:0];
                state_next = (w_reg > count_reg) ? ST_HEAD_RD : ST_POP_USE;
            end
            ST_POP_USE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(w_reg - 1'b1);
                w_next     = w_reg + 1'b1;
                state_next = ST_POP_RD;
            end
            ST_HEAD_RD:
            begin
                ram_raddr  = '0;
                state_next = (count_reg == '0) ? ST_DONE : ST_HEAD_USE;
            end
            ST_HEAD_USE:
            begin
                htag_next  = ram_rdata.tag;
                hlen_next  = ram_rdata.len;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status         = status_reg;
        res.channel_state  = link_reg;
        res.queued_bytes   = total_reg;
        res.queue_count    = 7'(count_reg);
        res.head_valid     = (count_reg != '0);
        res.head_tag       = (count_reg != '0) ? htag_reg : 16'd0;
        res.head_remaining = (count_reg != '0) ? (hlen_reg - off_reg) : 16'd0;
        res.packet_done    = done_reg;
    end

endmodule

### hw/rtl/coalescing_priority_send_queue.sv
// ---------------------------------------------------------------------------
// Coalescing priority send queue
// Transmit descriptor queue with class rules, byte budget and send tracking.
// ---------------------------------------------------------------------------
// Sequence: an accepted beat is decoded, then any discard, insert or pop walk
// runs over the queued entries, the head entry is read and the result is
// registered at the output; the walk visits each entry with a read and a use state.
// Flow: one beat at a time; the next beat is taken in the cycle after the result
// leaves the sequencer, and the walk over the simple dual-port descriptor RAM sets when.
// Reset: asynchronous; queue empty, channel connected, budget 16776960.
// RAM contents are not cleared; only entries below the count are read.
// ---------------------------------------------------------------------------
module coalescing_priority_send_queue #(
    parameter int QUEUE_DEPTH      = 64,
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wen,
    input  logic [23:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // class, lifecycle_kind, coalesce_key, packet_length, packet_tag,
    // send_status, sent_bytes, pad
    input  logic [119:0] s_tdata,
    // command
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, channel_state, queued_bytes, queue_count, head_valid,
    // head_tag, head_remaining, packet_done, pad
    output logic [71:0]  m_tdata
);
    import cpsq_pkg::*;

    logic        [23:0] budget_reg;
    item_t              item;
    result_t            res;
    logic               res_valid, res_ready;
    logic               m_tvalid_reg;
    logic        [71:0] m_tdata_reg;

    assign item.command        = s_tuser;
    assign item.packet_class   = s_tdata[2:0];
    assign item.lifecycle_kind = s_tdata[4:3];
    assign item.coalesce_key   = s_tdata[68:5];
    assign item.packet_length  = s_tdata[84:69];
    assign item.packet_tag     = s_tdata[100:85];
    assign item.send_status    = s_tdata[102:101];
    assign item.sent_bytes     = s_tdata[118:103];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= BUDGET_RESET;
        end
        else if (cfg_wen)
        begin
            budget_reg <= cfg_wdata;
        end
    end

    cpsq_ctrl #(
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (item),
        .budget   (budget_reg),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_tdata_reg <= {2'b00, res.packet_done, res.head_remaining, res.head_tag,
                            res.head_valid, res.queue_count, res.queued_bytes,
                            res.channel_state, res.status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### hw/rtl/cpsq_checker.sv
// ---------------------------------------------------------------------------
// Send queue port checker
// Port-level properties of the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "coalescing_priority_send_queue_defines.svh"

module cpsq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);
    import cpsq_pkg::*;

    `CPSQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
    `CPSQ_ASSERT_NOW(a_head_flag, m_tvalid, m_tdata[36] == (m_tdata[35:29] != 7'd0), "head valid disagrees with count")
    `CPSQ_ASSERT_NOW(a_empty_head, m_tvalid && !m_tdata[36], m_tdata[52:37] == 16'd0 && m_tdata[68:53] == 16'd0 && m_tdata[28:5] == 24'd0, "empty queue reports head data")
    `CPSQ_ASSERT_NOW(a_fault_clear, m_tvalid && (m_tdata[2:0] == STAT_SEND_FAIL || m_tdata[2:0] == STAT_QUEUE_FULL || m_tdata[2:0] == STAT_BUDGET), m_tdata[4:3] == LINK_FAILED && m_tdata[35:29] == 7'd0, "fault did not clear the queue")

endmodule

bind coalescing_priority_send_queue cpsq_checker u_cpsq_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
